### src/transaction_id_map_with_timeout_macros.svh
// assertion macros used by the checker file
`ifndef TRANSACTION_ID_MAP_WITH_TIMEOUT_MACROS_SVH
`define TRANSACTION_ID_MAP_WITH_TIMEOUT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TIDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tidm same-cycle check failed");

// next-cycle implication, disabled while in reset
`define TIDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tidm next-cycle check failed");

`endif

### src/tidm_pkg.sv
// shared widths, codes and record types of the transaction id map
`default_nettype none

package tidm_pkg;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 16;
    localparam int EP_W    = 48;
    localparam int QUERY_W = 16;
    localparam int TICK_W  = 10;
    localparam int KIND_W  = 3;
    localparam int SLOT_W  = 6;

    // number of distinct tick codes on the input
    localparam int TICK_RANGE = 1 << TICK_W;

    localparam logic [TICK_W-1:0] TTL_RESET = 10'd10;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;

    localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MATCH   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]   cid;
        logic [EP_W-1:0]   cep;
        logic [TICK_W-1:0] stamp;
    } tidm_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   orig_id;
        logic [EP_W-1:0]   endpoint_out;
    } tidm_result_t;

endpackage

`default_nettype wire

### src/tidm_req_if.sv
// request channel: valid/ready handshake with the input fields
`default_nettype none

interface tidm_req_if
    import tidm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    client_id;
    logic [EP_W-1:0]    client_endpoint;
    logic [QUERY_W-1:0] slot_query;
    logic [TICK_W-1:0]  now_tick;

    modport source (
        output valid, cmd, client_id, client_endpoint, slot_query, now_tick,
        input  ready
    );

    modport sink (
        input  valid, cmd, client_id, client_endpoint, slot_query, now_tick,
        output ready
    );
endinterface

`default_nettype wire

### src/tidm_res_if.sv
// result channel: valid/ready handshake with the result fields
`default_nettype none

interface tidm_res_if
    import tidm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   orig_id;
    logic [EP_W-1:0]   endpoint_out;
    logic              last;

    modport source (
        output valid, kind, slot, orig_id, endpoint_out, last,
        input  ready
    );

    modport sink (
        input  valid, kind, slot, orig_id, endpoint_out, last,
        output ready
    );
endinterface

`default_nettype wire

### src/transaction_id_map_with_timeout.sv
// top level: transaction id map with per-slot timeout
`default_nettype none

// Keeps TABLE_SLOTS outstanding request slots (busy flag, client id, client
// endpoint, time stamp). One request is worked on at a time; req.ready is
// high only while the sequencer is idle, and a finished result may still
// wait in the output register while the next request is taken. An allocate
// or sweep request first reduces now_tick modulo TIME_WRAP in
// clog2(1024/TIME_WRAP + 1) steps of the shift/subtract unit, then sweeps
// all slots for timeouts; an allocate then scans for a free slot, while a
// response request reads the queried slot and frees it on a match. The
// sweep walks the slot memory one slot a cycle through its single read port
// (the registered read of one slot overlaps the age compare of the slot
// before) unless a timeout result has to wait for room; the scan walks the
// busy flags one slot a cycle from a rotating start. The result side only
// holds up the sequencer once the lookahead and the output register are
// both full and another result is due, or when the final result finds the
// output register still occupied; it then waits while res.ready stays low.
// Timeouts are reported in slot order, for an allocate ahead of the grant or
// full result; a sweep that frees nothing reports a none result instead.
// The last result of each request carries last. Busy flags sit in
// flip-flops and reset clears them at once, so there is no clearing pass
// after reset. The ttl register is written through cfg_wr_en / cfg_wr_data
// and must only change while idle.
module transaction_id_map_with_timeout
    import tidm_pkg::*;
#(
    parameter int TABLE_SLOTS = 32,
    parameter int TIME_WRAP   = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tidm_req_if.sink               req,
    tidm_res_if.source             res,
    input  wire logic              cfg_wr_en,
    input  wire logic [TICK_W-1:0] cfg_wr_data
);

    // slot index and slot counter widths
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    // modulo reduction: one conditional subtract of TIME_WRAP << k per step
    localparam int STEPS = $clog2(TICK_RANGE / TIME_WRAP + 1);
    localparam int KW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int SH_W  = TICK_W + 7;

    localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [TICK_W:0]   WRAP_AGE  = (TICK_W + 1)'(TIME_WRAP);
    localparam logic [QUERY_W-1:0] SLOTS_Q  = QUERY_W'(TABLE_SLOTS);
    localparam logic [KW-1:0]     K_START   = KW'(STEPS - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_REDUCE  = 3'd1;
    localparam logic [2:0] ST_SWEEP   = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_RESP_RD = 3'd4;
    localparam logic [2:0] ST_RESP    = 3'd5;
    localparam logic [2:0] ST_NONE    = 3'd6;
    localparam logic [2:0] ST_FINAL   = 3'd7;

    logic [2:0] state_reg, state_next;

    // request fields held for the whole request (now is reduced modulo TIME_WRAP in place)
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [EP_W-1:0]    ep_reg, ep_next;
    logic [QUERY_W-1:0] query_reg, query_next;
    logic [TICK_W-1:0]  now_reg, now_next;

    logic [TICK_W-1:0] ttl_reg;

    // reduction step counter
    logic [KW-1:0] k_reg, k_next;

    // sweep: issue pointer and compare stage
    logic [CNT_W-1:0] p_reg, p_next;
    logic             e_valid_reg, e_valid_next;
    logic [IDX_W-1:0] e_idx_reg, e_idx_next;

    // scan: current slot and slots visited
    logic [IDX_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] next_start_reg, next_start_next;

    logic [TABLE_SLOTS-1:0] busy_reg, busy_next;

    // one-result lookahead so the final result can be marked last
    logic         hold_valid_reg, hold_valid_next;
    tidm_result_t hold_reg, hold_next;

    // output register
    logic         out_valid_reg, out_valid_next;
    tidm_result_t out_reg, out_next;
    logic         out_last_reg, out_last_next;

    // memory port
    logic        mem_wr_en;
    logic        mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    tidm_entry_t mem_wr_data;
    tidm_entry_t mem_rd_data;

    // shared unit results
    logic [SH_W-1:0]   wrap_shift;
    logic              reduce_take;
    logic [TICK_W:0]   age;
    logic              timed_out;

    logic         out_free;
    logic         can_produce;
    logic         prod_en;
    tidm_result_t prod_data;
    logic         ev_hit;
    logic         issue;
    logic         resp_hit;
    logic [IDX_W-1:0] query_idx;

    tidm_slot_ram #(
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (s_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign mem_wr_data = '{cid: id_reg, cep: ep_reg, stamp: now_reg};
    assign query_idx   = query_reg[IDX_W-1:0];

    // shift/subtract step of the modulo reduction
    assign wrap_shift  = SH_W'(TIME_WRAP) << k_reg;
    assign reduce_take = (SH_W'(now_reg) >= wrap_shift);

    // age of the slot in the compare stage, modulo the time wrap
    always_comb
    begin
        if (now_reg >= mem_rd_data.stamp)
        begin
            age = (TICK_W + 1)'(now_reg) - (TICK_W + 1)'(mem_rd_data.stamp);
        end
        else
        begin
            age = (TICK_W + 1)'(now_reg) + WRAP_AGE - (TICK_W + 1)'(mem_rd_data.stamp);
        end
    end

    assign timed_out   = (age > (TICK_W + 1)'(ttl_reg));
    assign out_free    = !out_valid_reg || res.ready;
    // a new result can go into the lookahead once the old one can move on
    assign can_produce = !hold_valid_reg || out_free;
    assign ev_hit      = e_valid_reg && busy_reg[e_idx_reg] && timed_out;
    assign issue       = (p_reg < SLOTS_C);
    assign resp_hit    = (query_reg < SLOTS_Q) && busy_reg[query_idx];

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        ep_next         = ep_reg;
        query_next      = query_reg;
        now_next        = now_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        e_valid_next    = e_valid_reg;
        e_idx_next      = e_idx_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        next_start_next = next_start_reg;
        busy_next       = busy_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = p_reg[IDX_W-1:0];
        prod_en         = 1'b0;
        prod_data       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.cmd;
                    id_next      = req.client_id;
                    ep_next      = req.client_endpoint;
                    query_next   = req.slot_query;
                    now_next     = req.now_tick;
                    k_next       = K_START;
                    p_next       = '0;
                    e_valid_next = 1'b0;
                    if (req.cmd == CMD_RESP)
                    begin
                        state_next = ST_RESP_RD;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                if (reduce_take)
                begin
                    now_next = now_reg - wrap_shift[TICK_W-1:0];
                end
                if (k_reg == '0)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end

            ST_SWEEP:
            begin
                // stall everything, read data included, until the timeout fits
                if (!(ev_hit && !can_produce))
                begin
                    if (ev_hit)
                    begin
                        prod_en              = 1'b1;
                        prod_data.kind       = KIND_TIMEOUT;
                        prod_data.slot       = SLOT_W'(e_idx_reg);
                        prod_data.orig_id    = mem_rd_data.cid;
                        prod_data.endpoint_out = mem_rd_data.cep;
                        busy_next[e_idx_reg] = 1'b0;
                    end
                    mem_rd_en    = issue;
                    e_valid_next = issue;
                    e_idx_next   = p_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        p_next = p_reg + 1'b1;
                    end
                    else if (cmd_reg == CMD_ALLOC)
                    begin
                        s_next     = next_start_reg;
                        n_next     = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_NONE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!busy_reg[s_reg])
                begin
                    if (can_produce)
                    begin
                        mem_wr_en        = 1'b1;
                        busy_next[s_reg] = 1'b1;
                        next_start_next  = (s_reg == LAST_IDX) ? '0 : s_reg + 1'b1;
                        prod_en          = 1'b1;
                        prod_data.kind   = KIND_GRANT;
                        prod_data.slot   = SLOT_W'(s_reg);
                        state_next       = ST_FINAL;
                    end
                end
                else if (n_reg == LAST_IDX)
                begin
                    if (can_produce)
                    begin
                        prod_en        = 1'b1;
                        prod_data.kind = KIND_FULL;
                        state_next     = ST_FINAL;
                    end
                end
                else
                begin
                    s_next = (s_reg == LAST_IDX) ? '0 : s_reg + 1'b1;
                    n_next = n_reg + 1'b1;
                end
            end

            ST_RESP_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = query_idx;
                state_next  = ST_RESP;
            end

            ST_RESP:
            begin
                // lookahead is empty here, so the result always fits
                prod_en    = 1'b1;
                state_next = ST_FINAL;
                if (resp_hit)
                begin
                    busy_next[query_idx]   = 1'b0;
                    prod_data.kind         = KIND_MATCH;
                    prod_data.slot         = SLOT_W'(query_idx);
                    prod_data.orig_id      = mem_rd_data.cid;
                    prod_data.endpoint_out = mem_rd_data.cep;
                end
                else
                begin
                    prod_data.kind = KIND_BAD;
                end
            end

            ST_NONE:
            begin
                // end of a sweep-only request; a none result is made only if it freed nothing
                if (!hold_valid_reg)
                begin
                    prod_en        = 1'b1;
                    prod_data.kind = KIND_NONE;
                end
                state_next = ST_FINAL;
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // new result enters the lookahead, pushing the older one out
        if (prod_en)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = prod_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ttl_reg        <= TTL_RESET;
            busy_reg       <= '0;
            next_start_reg <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            e_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            next_start_reg <= next_start_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            e_valid_reg    <= e_valid_next;
            if (cfg_wr_en)
            begin
                ttl_reg <= cfg_wr_data;
            end
        end
    end

    // payload and counters, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        ep_reg       <= ep_next;
        query_reg    <= query_next;
        now_reg      <= now_next;
        k_reg        <= k_next;
        p_reg        <= p_next;
        e_idx_reg    <= e_idx_next;
        s_reg        <= s_next;
        n_reg        <= n_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.slot         = out_reg.slot;
    assign res.orig_id      = out_reg.orig_id;
    assign res.endpoint_out = out_reg.endpoint_out;
    assign res.last         = out_last_reg;

endmodule

`default_nettype wire

### src/tidm_slot_ram.sv
// slot record memory: one write port, one registered read port
`default_nettype none

module tidm_slot_ram
    import tidm_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire tidm_entry_t wr_data,
    input  wire logic        rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output tidm_entry_t      rd_data
);

    tidm_entry_t mem [DEPTH];
    tidm_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/tidm_checker.sv
// port-level checks of the transaction id map, bound to the top level
`default_nettype none

`include "transaction_id_map_with_timeout_macros.svh"

module tidm_checker
    import tidm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [KIND_W-1:0] res_kind,
    input wire logic [SLOT_W-1:0] res_slot,
    input wire logic [ID_W-1:0]   res_orig_id,
    input wire logic              res_last
);

    // one request at a time: the block goes busy right after taking one
    `TIDM_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // only timeouts can be followed by more results of the same request
    `TIDM_ASSERT_NOW(a_only_timeout_not_last, clk, rst_n, res_valid && !res_last, res_kind == KIND_TIMEOUT)

    // results with no slot carry zero slot and id
    `TIDM_ASSERT_NOW(a_empty_fields_zero, clk, rst_n, res_valid && (res_kind == KIND_FULL || res_kind == KIND_BAD || res_kind == KIND_NONE), res_slot == '0 && res_orig_id == '0)

    // a stalled result holds
    `TIDM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_slot) && $stable(res_last))

endmodule

bind transaction_id_map_with_timeout tidm_checker u_tidm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_kind    (res.kind),
    .res_slot    (res.slot),
    .res_orig_id (res.orig_id),
    .res_last    (res.last)
);

`default_nettype wire
